// File: src/dns_name_label_encoder_unit_macros.svh
// assertion macros for the dns name label encoder
// used by the checker; needs a clk and an arst_n in the scope of each use
`ifndef DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DNLE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dnle_pkg.sv
// shared types and constants of the dns name label encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

	localparam int MaxLabel   = 63;
	localparam int StoreDepth = 63;
	localparam int LaneCount  = 8;
	localparam int LaneW      = $clog2(LaneCount);
	localparam int RowCount   = (StoreDepth + LaneCount - 1) / LaneCount;
	localparam int RowW       = $clog2(RowCount);
	localparam int CountW     = 6;
	localparam int TotalW     = CountW + 1;
	localparam int WordIdxW   = TotalW - LaneW;
	localparam int WordW      = 64;
	localparam int ByteCountW = 4;

	localparam logic [7:0] ChEnd = 8'd0;
	localparam logic [7:0] ChDot = 8'd46;

	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_LEAD_DOT  = 3'd1,
		PH_IN_LABEL  = 3'd2,
		PH_AFTER_DOT = 3'd3,
		PH_DISCARD   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		FL_IDLE = 2'd0,
		FL_READ = 2'd1,
		FL_EMIT = 2'd2,
		FL_BAD  = 2'd3
	} flush_state_t;

	// byte write into the label store
	typedef struct packed {
		logic             we;
		logic [RowW-1:0]  row;
		logic [LaneW-1:0] lane;
		logic [7:0]       data;
	} store_wr_t;

	// run request from the parser to the packer
	typedef struct packed {
		logic              run;
		logic              bad;
		logic [CountW-1:0] len;
		logic              term;
		logic              done;
	} run_req_t;

endpackage

`default_nettype wire

// File: src/dnle_label_mem.sv
// label store: rows of eight bytes, byte-lane write, registered row read
// depends on dnle_pkg
`timescale 1ns / 1ps
`default_nettype none

module dnle_label_mem (
	input  wire                                          clk,
	input  dnle_pkg::store_wr_t                          wr,
	input  wire                                          rd_en,
	input  wire  [dnle_pkg::RowW-1:0]                    rd_row,
	output logic [dnle_pkg::LaneCount*8-1:0]             rd_data
);
	import dnle_pkg::*;

	logic [LaneCount*8-1:0] mem_q [RowCount];
	logic [LaneCount*8-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.row][{wr.lane, 3'b000} +: 8] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_row];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: src/dnle_parser.sv
// name parser: phase tracking, label byte writes and run requests
// depends on dnle_pkg
`timescale 1ns / 1ps
`default_nettype none

module dnle_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire  [7:0]           name_char,
	output dnle_pkg::store_wr_t  wr,
	output dnle_pkg::run_req_t   req
);
	import dnle_pkg::*;

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] count_q, count_d;
	logic              is_end, is_dot;

	assign is_end = (name_char == ChEnd);
	assign is_dot = (name_char == ChDot);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_LEAD_DOT: phase_d = is_end ? PH_START : PH_DISCARD;
				PH_IN_LABEL: begin
					if (is_end)
						phase_d = PH_START;
					else if (is_dot)
						phase_d = PH_AFTER_DOT;
					else if (count_q >= CountW'(MaxLabel))
						phase_d = PH_DISCARD;
				end
				PH_AFTER_DOT: begin
					if (is_end)
						phase_d = PH_START;
					else if (is_dot)
						phase_d = PH_DISCARD;
					else
						phase_d = PH_IN_LABEL;
				end
				PH_DISCARD: begin
					if (is_end)
						phase_d = PH_START;
				end
				default: begin
					if (is_end)
						phase_d = PH_START;
					else if (is_dot)
						phase_d = PH_LEAD_DOT;
					else
						phase_d = PH_IN_LABEL;
				end
			endcase
		end
	end

	// writes, count and run requests
	always_comb begin
		wr.we    = 1'b0;
		wr.row   = count_q[CountW-1:LaneW];
		wr.lane  = count_q[LaneW-1:0];
		wr.data  = name_char;
		req.run  = 1'b0;
		req.bad  = 1'b0;
		req.len  = '0;
		req.term = 1'b0;
		req.done = 1'b0;
		count_d  = count_q;
		if (accept) begin
			unique case (phase_q)
				PH_LEAD_DOT: begin
					if (is_end) begin
						req.run  = 1'b1;
						req.done = 1'b1;
					end else begin
						req.bad = 1'b1;
						count_d = '0;
					end
				end
				PH_IN_LABEL: begin
					if (is_end || is_dot) begin
						req.run  = 1'b1;
						req.len  = count_q;
						req.term = is_end;
						req.done = is_end;
						count_d  = '0;
					end else if (count_q >= CountW'(MaxLabel)) begin
						req.bad = 1'b1;
						count_d = '0;
					end else begin
						wr.we   = 1'b1;
						count_d = count_q + CountW'(1);
					end
				end
				PH_AFTER_DOT: begin
					if (is_end) begin
						req.run  = 1'b1;
						req.done = 1'b1;
					end else if (is_dot) begin
						req.bad = 1'b1;
						count_d = '0;
					end else begin
						wr.we   = 1'b1;
						wr.row  = '0;
						wr.lane = '0;
						count_d = CountW'(1);
					end
				end
				PH_DISCARD: begin
					if (is_end)
						count_d = '0;
				end
				default: begin
					count_d = '0;
					if (is_end) begin
						req.run  = 1'b1;
						req.done = 1'b1;
					end else if (!is_dot) begin
						wr.we   = 1'b1;
						wr.row  = '0;
						wr.lane = '0;
						count_d = CountW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: src/dnle_packer.sv
// run packer: reads store rows and builds 64-bit result words into the output register
// depends on dnle_pkg
`timescale 1ns / 1ps
`default_nettype none

module dnle_packer (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  dnle_pkg::run_req_t                    req,
	output logic                                  idle,
	output logic                                  rd_en,
	output logic [dnle_pkg::RowW-1:0]             rd_row,
	input  wire  [dnle_pkg::LaneCount*8-1:0]      rd_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [dnle_pkg::WordW-1:0]            data_word,
	output logic [dnle_pkg::ByteCountW-1:0]       byte_count,
	output logic                                  run_last,
	output logic                                  name_done,
	output logic                                  bad_name
);
	import dnle_pkg::*;

	flush_state_t        state_q, state_d;
	logic [CountW-1:0]   len_q;
	logic [TotalW-1:0]   total_q;
	logic                done_q;
	logic [WordIdxW-1:0] word_q;
	logic [7:0]          carry_q;
	logic                valid_q;
	logic [WordW-1:0]    word_out_q;
	logic [ByteCountW-1:0] count_out_q;
	logic                last_out_q, done_out_q, bad_out_q;

	logic                slot_free, load_word, load_bad;
	logic [TotalW-1:0]   remain;
	logic                is_last;
	logic [ByteCountW-1:0] cnt;
	logic [WordW-1:0]    word_raw, word_masked;
	logic [TotalW-1:0]   byte_idx;

	assign slot_free = !valid_q || out_ready;

	// bytes still to go in this run, and the count for the current word
	assign remain  = total_q - {word_q, {LaneW{1'b0}}};
	assign is_last = (remain <= TotalW'(LaneCount));
	assign cnt     = is_last ? remain[ByteCountW-1:0] : ByteCountW'(LaneCount);

	// word k = byte seven of row k-1 (length byte for k = 0), then row k bytes zero to six
	assign word_raw = {rd_data[(LaneCount-1)*8-1:0], carry_q};

	// zero every byte past the label and the terminator
	always_comb begin
		word_masked = '0;
		byte_idx    = '0;
		for (int j = 0; j < LaneCount; j++) begin
			byte_idx = {word_q, LaneW'(j)};
			if (byte_idx <= {1'b0, len_q})
				word_masked[j*8 +: 8] = word_raw[j*8 +: 8];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FL_IDLE: begin
				if (req.bad)
					state_d = FL_BAD;
				else if (req.run)
					state_d = FL_READ;
			end
			FL_READ: state_d = FL_EMIT;
			FL_EMIT: begin
				if (slot_free)
					state_d = is_last ? FL_IDLE : FL_READ;
			end
			FL_BAD: begin
				if (slot_free)
					state_d = FL_IDLE;
			end
			default: state_d = FL_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		idle      = (state_q == FL_IDLE);
		rd_en     = (state_q == FL_READ);
		rd_row    = word_q[RowW-1:0];
		load_word = (state_q == FL_EMIT) && slot_free;
		load_bad  = (state_q == FL_BAD) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FL_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_word || load_bad)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (idle && req.run) begin
			len_q   <= req.len;
			total_q <= {1'b0, req.len} + TotalW'(1) + TotalW'(req.term);
			done_q  <= req.done;
			word_q  <= '0;
			carry_q <= {{(8-CountW){1'b0}}, req.len};
		end else if (load_word) begin
			word_q  <= word_q + WordIdxW'(1);
			carry_q <= rd_data[LaneCount*8-1 -: 8];
		end
		if (load_word) begin
			word_out_q  <= word_masked;
			count_out_q <= cnt;
			last_out_q  <= is_last;
			done_out_q  <= done_q;
			bad_out_q   <= 1'b0;
		end else if (load_bad) begin
			word_out_q  <= '0;
			count_out_q <= '0;
			last_out_q  <= 1'b1;
			done_out_q  <= 1'b1;
			bad_out_q   <= 1'b1;
		end
	end

	assign out_valid  = valid_q;
	assign data_word  = word_out_q;
	assign byte_count = count_out_q;
	assign run_last   = last_out_q;
	assign name_done  = done_out_q;
	assign bad_name   = bad_out_q;

endmodule

`default_nettype wire

// File: src/dns_name_label_encoder_unit.sv
// top level of the dns name label encoder
// depends on dnle_pkg, dnle_label_mem, dnle_parser and dnle_packer
`timescale 1ns / 1ps
`default_nettype none

// usage
// - s_axis carries one name character per request in tdata; 0 ends the name,
//   '.' separates labels, anything else is a label byte
// - m_axis carries encoded words: length byte, label bytes, then the zero
//   terminator at the end of the name, little-endian, first byte in bits 7:0
// - a label byte goes straight into the store; a dot or the end character
//   starts a flush of w = ceil(bytes / 8) words (at most nine); each word
//   takes one row read of the label store, then a load of the output register
// - the label store is a single-port-read memory of eight 8-byte rows, which
//   forces a separate read per word; s_axis_tready is low for the whole flush
// - an empty or overlong label gives one bad_name request with byte_count 0;
//   the rest of the name is then swallowed up to its end character
// - a stalled receiver holds the output register; the block keeps taking
//   label bytes meanwhile and only a new flush waits for the slot
// - reset clears the phase, label count and output valid; the store itself
//   is not cleared and needs no clearing pass since only written bytes are read
module dns_name_label_encoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	// name_char [7:0]
	input  wire  [7:0]  s_axis_tdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// data_word [63:0], byte_count [67:64], zero fill [71:68]
	output logic [71:0] m_axis_tdata,
	// name_done [0], bad_name [1]
	output logic [1:0]  m_axis_tuser,
	// run_last
	output logic        m_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready
);
	import dnle_pkg::*;

	store_wr_t                 wr;
	run_req_t                  req;
	logic                      accept;
	logic                      idle;
	logic                      rd_en;
	logic [RowW-1:0]           rd_row;
	logic [LaneCount*8-1:0]    rd_data;
	logic [WordW-1:0]          data_word;
	logic [ByteCountW-1:0]     byte_count;
	logic                      run_last, name_done, bad_name;

	// requests are only taken while no flush is in progress
	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && idle;

	dnle_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.name_char (s_axis_tdata),
		.wr        (wr),
		.req       (req)
	);

	dnle_label_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	dnle_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.idle       (idle),
		.rd_en      (rd_en),
		.rd_row     (rd_row),
		.rd_data    (rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.run_last   (run_last),
		.name_done  (name_done),
		.bad_name   (bad_name)
	);

	// pack the result fields onto the stream
	assign m_axis_tdata = {4'b0000, byte_count, data_word};
	assign m_axis_tuser = {bad_name, name_done};
	assign m_axis_tlast = run_last;

endmodule

`default_nettype wire

// File: src/dnle_checker.sv
// port-level checker for the dns name label encoder, bound to the top level
// depends on dns_name_label_encoder_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "dns_name_label_encoder_unit_macros.svh"

module dnle_checker (
	input wire        clk,
	input wire        arst_n,
	input wire [71:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser,
	input wire        m_axis_tlast,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready
);

	// a stalled request stays and holds its data
	`DNLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
	`DNLE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed while stalled")

	// bad name result is empty, last and ends the name
	`DNLE_ASSERT_IMPL(a_bad_shape, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == 72'd0), "malformed bad name result")

	// ordinary words carry one to eight bytes
	`DNLE_ASSERT_IMPL(a_count_range, m_axis_tvalid && !m_axis_tuser[1], (m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'd8), "byte count out of range")

	// only the last word of a run may be partly filled
	`DNLE_ASSERT_IMPL(a_full_inner, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[67:64] == 4'd8, "inner word not full")

endmodule

bind dns_name_label_encoder_unit dnle_checker u_dnle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

`default_nettype wire

// File: tb/tb_top.sv
// self-checking bench for dns_name_label_encoder_unit: directed and random names
// go in on s_axis, encoded words are predicted in the bench and checked on m_axis
// depends on dnle_pkg and the encoder rtl
`timescale 1ns / 1ps

module tb_top;
	import dnle_pkg::*;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
		logic        done;
		logic        bad;
	} enc_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic [7:0]  s_data = 8'd0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [71:0] m_data;
	logic [1:0]  m_user;
	logic        m_last;
	logic        m_valid;
	logic        m_ready = 1'b0;

	// when set neither side idles
	logic steady = 1'b0;

	int items_sent;
	int fail_count;

	// bench copy of the encoder state
	logic [7:0] label_bytes [MaxLabel];
	logic [5:0] label_len;
	phase_t     name_state;
	logic [7:0] run_bytes [MaxLabel + 2];
	int         run_len;
	enc_word_t  expected_words [$];

	dns_name_label_encoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pack run_bytes little-endian into words of up to eight bytes
	function automatic void push_run(input logic done);
		int words;
		int cnt;
		logic [63:0] w;
		enc_word_t item;
		words = (run_len + 7) / 8;
		for (int k = 0; k < words; k++) begin
			w = 64'd0;
			cnt = run_len - k * 8;
			if (cnt > 8)
				cnt = 8;
			for (int i = 0; i < cnt; i++)
				w = w | (64'(run_bytes[k * 8 + i]) << (8 * i));
			item.word   = w;
			item.nbytes = cnt[3:0];
			item.last   = (k + 1 == words);
			item.done   = done;
			item.bad    = 1'b0;
			expected_words.push_back(item);
		end
	endfunction

	function automatic void flush_label(input logic with_end);
		run_bytes[0] = {2'b00, label_len};
		for (int i = 0; i < label_len; i++)
			run_bytes[1 + i] = label_bytes[i];
		run_len = label_len + 1;
		if (with_end) begin
			run_bytes[run_len] = ChEnd;
			run_len++;
		end
		label_len = '0;
		push_run(with_end);
	endfunction

	function automatic void end_only();
		run_bytes[0] = ChEnd;
		run_len = 1;
		push_run(1'b1);
	endfunction

	function automatic void reject_name();
		enc_word_t item;
		item.word   = 64'd0;
		item.nbytes = 4'd0;
		item.last   = 1'b1;
		item.done   = 1'b1;
		item.bad    = 1'b1;
		expected_words.push_back(item);
		label_len  = '0;
		name_state = PH_DISCARD;
	endfunction

	function automatic void store_char(input logic [7:0] c);
		if (label_len < MaxLabel)
			label_bytes[label_len] = c;
		label_len = label_len + 6'd1;
	endfunction

	// next state and expected words for one accepted character
	function automatic void encode_char(input logic [7:0] c);
		case (name_state)
			PH_LEAD_DOT: begin
				if (c == ChEnd) begin
					name_state = PH_START;
					end_only();
				end else
					reject_name();
			end
			PH_IN_LABEL: begin
				if (c == ChEnd) begin
					name_state = PH_START;
					flush_label(1'b1);
				end else if (c == ChDot) begin
					name_state = PH_AFTER_DOT;
					flush_label(1'b0);
				end else if (label_len >= MaxLabel)
					reject_name();
				else
					store_char(c);
			end
			PH_AFTER_DOT: begin
				if (c == ChEnd) begin
					name_state = PH_START;
					end_only();
				end else if (c == ChDot)
					reject_name();
				else begin
					label_len = '0;
					store_char(c);
					name_state = PH_IN_LABEL;
				end
			end
			PH_DISCARD: begin
				if (c == ChEnd) begin
					name_state = PH_START;
					label_len  = '0;
				end
			end
			default: begin
				name_state = PH_START;
				label_len  = '0;
				if (c == ChEnd)
					end_only();
				else if (c == ChDot)
					name_state = PH_LEAD_DOT;
				else begin
					store_char(c);
					name_state = PH_IN_LABEL;
				end
			end
		endcase
	endfunction

	// one character request; called at a rising edge, returns at the accepting edge
	task automatic send_char(input logic [7:0] c);
		if (!steady && $urandom_range(99) < 12) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_data  <= c;
		s_valid <= 1'b1;
		do
			@(posedge clk);
		while (!s_ready);
		encode_char(c);
		items_sent++;
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i]);
	endtask

	// n random label bytes, never a dot or the end character
	task automatic send_label(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			do
				b = 8'($urandom_range(1, 255));
			while (b == ChDot);
			send_char(b);
		end
	endtask

	task automatic report_mismatch(input string what, input enc_word_t want,
			input enc_word_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected word %h count %0d last %b done %b bad %b, got word %h count %0d last %b done %b bad %b",
				what, want.word, want.nbytes, want.last, want.done, want.bad,
				got.word, got.nbytes, got.last, got.done, got.bad);
	endtask

	// result side: check on each accepted word, then pick the next stall
	always @(posedge clk) begin
		enc_word_t got;
		enc_word_t want;
		if (arst_n && m_valid && m_ready) begin
			got.word   = m_data[63:0];
			got.nbytes = m_data[67:64];
			got.last   = m_last;
			got.done   = m_user[0];
			got.bad    = m_user[1];
			if (expected_words.size() == 0)
				report_mismatch("unexpected word", '0, got);
			else begin
				want = expected_words.pop_front();
				if (got.word !== want.word || got.nbytes !== want.nbytes
						|| got.last !== want.last || got.done !== want.done
						|| got.bad !== want.bad)
					report_mismatch("mismatch", want, got);
			end
		end
		m_ready <= steady || ($urandom_range(99) >= 12);
	end

	task automatic test_empty_names();
		send_char(ChEnd);
		send_char(ChDot);
		send_char(ChEnd);
	endtask

	task automatic test_short_names();
		send_text("a");
		send_char(ChEnd);
		// extreme byte values, trailing dot
		send_char(8'hFF);
		send_char(8'h01);
		send_char(ChDot);
		send_char(8'h80);
		send_char(ChDot);
		send_char(ChEnd);
	endtask

	task automatic test_bad_names();
		// leading dot then a label, rest swallowed
		send_text(".x");
		send_char(8'hFF);
		send_char(ChEnd);
		// empty label between two dots
		send_text("a..b.");
		send_char(ChEnd);
		// two dots at the start
		send_text("..");
		send_char(ChEnd);
	endtask

	task automatic test_label_lengths();
		// word boundaries: 7 bytes fill one word with the length byte
		send_label(7);
		send_char(ChDot);
		send_label(8);
		send_char(ChEnd);
		// longest label: nine words with the terminator, no idling on either side
		steady = 1'b1;
		send_label(MaxLabel);
		send_char(ChEnd);
		steady = 1'b0;
		// one byte too many
		send_label(MaxLabel + 1);
		send_char(ChEnd);
	endtask

	task automatic test_random_names();
		int first;
		int pick;
		int labels;
		int len;
		first = items_sent;
		while (items_sent - first < 16) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				// well-formed name
				labels = $urandom_range(1, 4);
				for (int l = 0; l < labels; l++) begin
					if ($urandom_range(9) == 0)
						len = $urandom_range(40, MaxLabel);
					else
						len = $urandom_range(1, 12);
					send_label(len);
					if (l + 1 < labels || $urandom_range(3) == 0)
						send_char(ChDot);
				end
				send_char(ChEnd);
			end else if (pick < 90) begin
				// broken name, then some swallowed bytes
				case ($urandom_range(2))
					0: begin
						send_char(ChDot);
						send_label(1);
					end
					1: begin
						send_label($urandom_range(1, 5));
						send_char(ChDot);
						send_char(ChDot);
					end
					default: send_label($urandom_range(MaxLabel + 1, MaxLabel + 4));
				endcase
				repeat ($urandom_range(0, 3))
					send_char(($urandom_range(1) == 0) ? ChDot : 8'($urandom_range(1, 255)));
				send_char(ChEnd);
			end else begin
				// loose characters, dots and ends weighted up
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(3))
						0: send_char(ChEnd);
						1: send_char(ChDot);
						default: send_char(8'($urandom));
					endcase
				end
			end
		end
	endtask

	initial begin
		items_sent = 0;
		fail_count = 0;
		label_len  = '0;
		name_state = PH_START;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_names();
		test_short_names();
		test_bad_names();
		test_label_lengths();
		test_random_names();
		// close an open name so the block ends at the start of a name
		send_char(ChEnd);
		s_valid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("** dns_name_label_encoder_unit: PASSED **");
		else
			$display("** dns_name_label_encoder_unit: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("** dns_name_label_encoder_unit: FAILED **");
		$finish;
	end

endmodule

// File: dns_name_label_encoder_unit.f
+incdir+src
src/dnle_pkg.sv
src/dnle_label_mem.sv
src/dnle_parser.sv
src/dnle_packer.sv
src/dns_name_label_encoder_unit.sv
src/dnle_checker.sv
tb/tb_top.sv
